/* rtl/slc_pkg.sv */
// shared types and constants for the two-cluster single-linkage splitter
`default_nettype none
package slc_pkg;

   localparam int MAX_SAMPLES = 256;
   localparam int IDX_W       = 8;
   localparam int CNT_W       = 9;
   localparam int VAL_W       = 8;
   localparam int DIST_W      = 9;

   localparam logic [DIST_W-1:0] NO_DIST = {DIST_W{1'b1}};
   localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_SAMPLES);
   localparam logic [CNT_W-1:0]  MIN_GROUPS = CNT_W'(2);

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic              take;
      logic [DIST_W-1:0] gap;
      logic [IDX_W-1:0]  lo;
      logic [IDX_W-1:0]  hi;
   } cmp_res_type;

   typedef struct packed {
      logic              overflow;
      logic              clustered;
      logic [CNT_W-1:0]  loaded_count;
      logic              index_valid;
      logic              label;
   } result_type;

endpackage
`default_nettype wire

/* rtl/slc_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module slc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/slc_cmp.sv */
// shared pair compare unit: distance and tie-ordered best-pair test
`default_nettype none
module slc_cmp (
   input  wire logic [slc_pkg::VAL_W-1:0]  sample_a,
   input  wire logic [slc_pkg::VAL_W-1:0]  sample_b,
   input  wire logic [slc_pkg::IDX_W-1:0]  leader_a,
   input  wire logic [slc_pkg::IDX_W-1:0]  leader_b,
   input  wire logic [slc_pkg::DIST_W-1:0] best_dist,
   input  wire logic [slc_pkg::IDX_W-1:0]  best_lo,
   input  wire logic [slc_pkg::IDX_W-1:0]  best_hi,
   output      slc_pkg::cmp_res_type       res
);

   logic [slc_pkg::VAL_W-1:0]  diff;
   logic [slc_pkg::DIST_W-1:0] gap;
   logic [slc_pkg::IDX_W-1:0]  lo;
   logic [slc_pkg::IDX_W-1:0]  hi;
   logic                       better;

   always_comb begin
      diff = (sample_a > sample_b) ? (sample_a - sample_b) : (sample_b - sample_a);
      gap  = slc_pkg::DIST_W'(diff);
      lo   = (leader_a < leader_b) ? leader_a : leader_b;
      hi   = (leader_a < leader_b) ? leader_b : leader_a;
      better = (gap < best_dist) ||
               ((gap == best_dist) && ((lo < best_lo) || ((lo == best_lo) && (hi < best_hi))));
      res.take = (leader_a != leader_b) && better;
      res.gap  = gap;
      res.lo   = lo;
      res.hi   = hi;
   end

endmodule
`default_nettype wire

/* rtl/single_link_two_cluster_split.sv */
// top level: sample store, cluster sequencer and result register
//
//   channel | group | direction | carries
//   request | req_  | in        | load a sample or read a label
//   result  | rsp_  | out       | one result per request
//
// a load answers straight from the accept; a label read goes through the store read and ST_RD
// a load marked last runs ST_INIT, then passes of pair scan and merge until at most two groups
// remain, and answers then; the pair scan goes through one read port of each store
// reset clears count, done flag, result valid and sequencer; store contents stay undefined
// a waiting result holds until taken; no request is taken while one is in work
`default_nettype none
module single_link_two_cluster_split (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,  // sample_value, read_index
   input  wire logic        req_tuser,  // func
   input  wire logic        req_tlast,  // last
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata   // label, index_valid, loaded_count, clustered, overflow
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_PASS, ST_A_RD, ST_A_LAT, ST_SCAN, ST_MERGE, ST_RELABEL, ST_RD
   } state_type;

   localparam int IW = slc_pkg::IDX_W;
   localparam int CW = slc_pkg::CNT_W;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        done_ff, done_in;
   logic [CW-1:0]               groups_ff, groups_in;
   logic [CW-1:0]               a_ff, a_in;
   logic [CW-1:0]               b_ff, b_in;
   logic                        pend_ff, pend_in;
   logic [IW-1:0]               prev_ff, prev_in;
   logic [slc_pkg::VAL_W-1:0]   sa_ff, sa_in;
   logic [IW-1:0]               la_ff, la_in;
   logic [slc_pkg::DIST_W-1:0]  best_d_ff, best_d_in;
   logic [IW-1:0]               best_lo_ff, best_lo_in;
   logic [IW-1:0]               best_hi_ff, best_hi_in;
   logic                        ovf_ff, ovf_in;
   logic                        rd_ok_ff, rd_ok_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   slc_pkg::result_type         out_ff, out_in;

   logic                        accept;
   logic [slc_pkg::VAL_W-1:0]   req_value;
   logic [IW-1:0]               req_index;
   logic [CW-1:0]               base_count;
   logic [IW-1:0]               rd_addr;
   logic                        smp_we;
   logic [IW-1:0]               smp_waddr;
   logic [slc_pkg::VAL_W-1:0]   smp_rd;
   logic                        ldr_we;
   logic [IW-1:0]               ldr_waddr;
   logic [IW-1:0]               ldr_wdata;
   logic [IW-1:0]               ldr_rd;
   slc_pkg::cmp_res_type        cmp_res;

   assign req_value  = req_tdata[7:0];
   assign req_index  = req_tdata[15:8];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign base_count = done_ff ? '0 : count_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff};

   slc_ram #(.WIDTH(slc_pkg::VAL_W), .DEPTH(slc_pkg::MAX_SAMPLES)) u_samples (
      .clock   (clock),
      .wr_en   (smp_we),
      .wr_addr (smp_waddr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (smp_rd)
   );

   slc_ram #(.WIDTH(IW), .DEPTH(slc_pkg::MAX_SAMPLES)) u_leaders (
      .clock   (clock),
      .wr_en   (ldr_we),
      .wr_addr (ldr_waddr),
      .wr_data (ldr_wdata),
      .rd_addr (rd_addr),
      .rd_data (ldr_rd)
   );

   slc_cmp u_cmp (
      .sample_a  (sa_ff),
      .sample_b  (smp_rd),
      .leader_a  (la_ff),
      .leader_b  (ldr_rd),
      .best_dist (best_d_ff),
      .best_lo   (best_lo_ff),
      .best_hi   (best_hi_ff),
      .res       (cmp_res)
   );

   always_comb begin
      unique case (state_ff)
         ST_IDLE: rd_addr = req_index;
         ST_SCAN: rd_addr = b_ff[IW-1:0];
         default: rd_addr = a_ff[IW-1:0];
      endcase
   end

   always_comb begin
      smp_we    = accept && (req_tuser == slc_pkg::FUNC_LOAD) && (base_count < slc_pkg::MAX_CNT);
      smp_waddr = base_count[IW-1:0];
      ldr_we    = 1'b0;
      ldr_waddr = a_ff[IW-1:0];
      ldr_wdata = a_ff[IW-1:0];
      if (state_ff == ST_INIT) begin
         ldr_we = (a_ff < count_ff);
      end else if (state_ff == ST_RELABEL) begin
         ldr_we    = pend_ff && (ldr_rd == best_hi_ff);
         ldr_waddr = prev_ff;
         ldr_wdata = best_lo_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      groups_in    = groups_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pend_in      = pend_ff;
      prev_in      = prev_ff;
      sa_in        = sa_ff;
      la_in        = la_ff;
      best_d_in    = best_d_ff;
      best_lo_in   = best_lo_ff;
      best_hi_in   = best_hi_ff;
      ovf_in       = ovf_ff;
      rd_ok_in     = rd_ok_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == slc_pkg::FUNC_LOAD) begin
                  done_in  = 1'b0;
                  ovf_in   = !(base_count < slc_pkg::MAX_CNT);
                  count_in = (base_count < slc_pkg::MAX_CNT) ? base_count + 1'b1 : base_count;
                  if (req_tlast) begin
                     groups_in = count_in;
                     a_in      = '0;
                     state_in  = ST_INIT;
                  end else begin
                     out_in.label        = 1'b0;
                     out_in.index_valid  = 1'b0;
                     out_in.loaded_count = count_in;
                     out_in.clustered    = 1'b0;
                     out_in.overflow     = ovf_in;
                     rsp_valid_in        = 1'b1;
                  end
               end else begin
                  rd_ok_in = done_ff && ({1'b0, req_index} < count_ff);
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            out_in.label        = rd_ok_ff && (ldr_rd != '0);
            out_in.index_valid  = rd_ok_ff;
            out_in.loaded_count = count_ff;
            out_in.clustered    = done_ff;
            out_in.overflow     = 1'b0;
            rsp_valid_in        = 1'b1;
            state_in            = ST_IDLE;
         end
         ST_INIT: begin
            if (a_ff < count_ff) begin
               a_in = a_ff + 1'b1;
            end else begin
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            if (groups_ff > slc_pkg::MIN_GROUPS) begin
               best_d_in  = slc_pkg::NO_DIST;
               best_lo_in = '0;
               best_hi_in = '0;
               a_in       = '0;
               state_in   = ST_A_RD;
            end else begin
               done_in             = 1'b1;
               out_in.label        = 1'b0;
               out_in.index_valid  = 1'b0;
               out_in.loaded_count = count_ff;
               out_in.clustered    = 1'b1;
               out_in.overflow     = ovf_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_A_RD: begin
            state_in = ST_A_LAT;
         end
         ST_A_LAT: begin
            sa_in = smp_rd;
            la_in = ldr_rd;
            if (a_ff + 1'b1 >= count_ff) begin
               state_in = ST_MERGE;
            end else begin
               b_in     = a_ff + 1'b1;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_ff && cmp_res.take) begin
               best_d_in  = cmp_res.gap;
               best_lo_in = cmp_res.lo;
               best_hi_in = cmp_res.hi;
            end
            if (b_ff < count_ff) begin
               pend_in = 1'b1;
               b_in    = b_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  a_in     = a_ff + 1'b1;
                  state_in = ST_A_RD;
               end
            end
         end
         ST_MERGE: begin
            a_in    = '0;
            pend_in = 1'b0;
            if (best_d_ff == slc_pkg::NO_DIST) begin
               groups_in = slc_pkg::MIN_GROUPS;
               state_in  = ST_PASS;
            end else begin
               state_in = ST_RELABEL;
            end
         end
         ST_RELABEL: begin
            if (a_ff < count_ff) begin
               pend_in = 1'b1;
               prev_in = a_ff[IW-1:0];
               a_in    = a_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  groups_in = groups_ff - 1'b1;
                  state_in  = ST_PASS;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      groups_ff  <= groups_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      prev_ff    <= prev_in;
      sa_ff      <= sa_in;
      la_ff      <= la_in;
      best_d_ff  <= best_d_in;
      best_lo_ff <= best_lo_in;
      best_hi_ff <= best_hi_in;
      ovf_ff     <= ovf_in;
      rd_ok_ff   <= rd_ok_in;
      out_ff     <= out_in;
   end

endmodule
`default_nettype wire
